/* sv/ecc_pkg.sv */
// shared types, constants and arithmetic helpers of the circle collision block
`timescale 1ns / 1ps

package ecc_pkg;

  // sqrt digits: root of a 66-bit sum of squares fits in 33 bits, 34 are formed
  localparam int unsigned SqrtSteps = 34;
  localparam int unsigned RootW     = SqrtSteps;
  localparam int unsigned SumSqW    = 2 * 33;

  // front to back queue
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // shared divider geometry: numerator, denominator and quotient widths
  localparam int unsigned DivNumW = 64;
  localparam int unsigned DivDenW = 34;
  localparam int unsigned DivQuoW = 32;

  // equal mass weight (one half in Q0.31)
  localparam logic [31:0] HalfQ31 = 32'h4000_0000;

  typedef logic [67:0]        prod_t;
  typedef logic signed [39:0] wide_t;

  typedef struct packed {
    logic signed [31:0] a_pos_x;
    logic signed [31:0] a_pos_y;
    logic signed [31:0] a_vel_x;
    logic signed [31:0] a_vel_y;
    logic [31:0]        a_radius;
    logic [31:0]        a_mass;
    logic signed [31:0] b_pos_x;
    logic signed [31:0] b_pos_y;
    logic signed [31:0] b_vel_x;
    logic signed [31:0] b_vel_y;
    logic [31:0]        b_radius;
    logic [31:0]        b_mass;
  } item_in_t;

  typedef struct packed {
    logic signed [31:0] new_a_pos_x;
    logic signed [31:0] new_a_pos_y;
    logic signed [31:0] new_a_vel_x;
    logic signed [31:0] new_a_vel_y;
    logic signed [31:0] new_b_pos_x;
    logic signed [31:0] new_b_pos_y;
    logic signed [31:0] new_b_vel_x;
    logic signed [31:0] new_b_vel_y;
    logic               collided;
  } item_out_t;

  // item plus centre offsets
  typedef struct packed {
    item_in_t           item;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
  } geo_t;

  // classified item handed from front to back
  typedef struct packed {
    geo_t             geo;
    logic [RootW-1:0] cdist;
    logic             hit;
  } fe_t;

  function automatic wide_t sx40(logic signed [31:0] v);
    return 40'(v);
  endfunction

  function automatic logic [39:0] mag40(wide_t v);
    return v[39] ? 40'(-v) : 40'(v);
  endfunction

  // round half away from zero, then shift right by s; sign applied last
  function automatic wide_t rnd_shift(prod_t p, logic neg, int unsigned s);
    prod_t r;
    r = (p + (prod_t'(1) << (s - 1))) >> s;
    return neg ? -$signed(r[39:0]) : $signed(r[39:0]);
  endfunction

  function automatic logic signed [31:0] sat32(wide_t v);
    logic signed [31:0] r;
    if (v > $signed(40'h00_7FFF_FFFF)) begin
      r = $signed(32'h7FFF_FFFF);
    end else if (v < $signed(40'hFF_8000_0000)) begin
      r = $signed(32'h8000_0000);
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

endpackage

/* sv/ecc_div.sv */
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module ecc_div #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 34,
  parameter int unsigned QuoW = 32
) (
  input  logic            clk_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [QuoW-1:0] quo_o
);

  localparam int unsigned RemW = (NumW > DenW + QuoW) ? NumW : DenW + QuoW;

  logic [RemW-1:0] rem_q [QuoW];
  logic [DenW-1:0] den_q [QuoW];
  logic [QuoW-1:0] quo_q [QuoW];

  for (genvar i = 0; i < QuoW; i++) begin : g_stage
    localparam int unsigned Bit = QuoW - 1 - i;
    logic [RemW-1:0] rem_in;
    logic [RemW-1:0] sub;
    logic [DenW-1:0] den_in;
    logic [QuoW-1:0] quo_in;

    if (i == 0) begin : g_first
      assign rem_in = RemW'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    assign sub = RemW'(den_in) << Bit;

    always_ff @(posedge clk_i) begin
      den_q[i] <= den_in;
      if (rem_in >= sub) begin
        rem_q[i] <= rem_in - sub;
        quo_q[i] <= quo_in | (QuoW'(1) << Bit);
      end else begin
        rem_q[i] <= rem_in;
        quo_q[i] <= quo_in;
      end
    end
  end

  assign quo_o = quo_q[QuoW-1];

endmodule

/* sv/ecc_front.sv */
// front end: centre offsets, pipelined distance sqrt and overlap test
`timescale 1ns / 1ps

module ecc_front import ecc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  item_in_t item_i,
  output logic     valid_o,
  output fe_t      ent_o
);

  localparam int unsigned FrontLat = SqrtSteps + 5;

  logic [FrontLat-1:0] vld_q;
  item_in_t            item0_q;
  geo_t                geo1_q;
  geo_t                geo2_q;
  logic [SumSqW-1:0]   sqx_q;
  logic [SumSqW-1:0]   sqy_q;
  logic [32:0]         mx;
  logic [32:0]         my;
  logic [SumSqW-1:0]   rem_q  [SqrtSteps+1];
  logic [RootW-1:0]    root_q [SqrtSteps+1];
  geo_t                geo_q  [SqrtSteps+1];
  fe_t                 ent_q;
  logic [RootW-1:0]    rsum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FrontLat-2:0], valid_i};
    end
  end

  assign mx = geo1_q.dx[32] ? 33'(-geo1_q.dx) : 33'(geo1_q.dx);
  assign my = geo1_q.dy[32] ? 33'(-geo1_q.dy) : 33'(geo1_q.dy);

  always_ff @(posedge clk_i) begin
    item0_q     <= item_i;
    geo1_q.item <= item0_q;
    geo1_q.dx   <= 33'(item0_q.b_pos_x) - 33'(item0_q.a_pos_x);
    geo1_q.dy   <= 33'(item0_q.b_pos_y) - 33'(item0_q.a_pos_y);
    geo2_q      <= geo1_q;
    sqx_q       <= SumSqW'(mx) * SumSqW'(mx);
    sqy_q       <= SumSqW'(my) * SumSqW'(my);
    geo_q[0]    <= geo2_q;
    rem_q[0]    <= sqx_q + sqy_q;
    root_q[0]   <= '0;
  end

  // one root bit per stage, most significant first
  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    localparam int unsigned K = SqrtSteps - 1 - j;
    logic [SumSqW+1:0] trial;
    logic [SumSqW+1:0] rem_ext;

    assign trial   = ((SumSqW+2)'(root_q[j]) << (K + 1)) + ((SumSqW+2)'(1) << (2 * K));
    assign rem_ext = (SumSqW+2)'(rem_q[j]);

    always_ff @(posedge clk_i) begin
      geo_q[j+1] <= geo_q[j];
      if (rem_ext >= trial) begin
        rem_q[j+1]  <= SumSqW'(rem_ext - trial);
        root_q[j+1] <= root_q[j] | (RootW'(1) << K);
      end else begin
        rem_q[j+1]  <= rem_q[j];
        root_q[j+1] <= root_q[j];
      end
    end
  end

  assign rsum = RootW'(geo_q[SqrtSteps].item.a_radius) + RootW'(geo_q[SqrtSteps].item.b_radius);

  always_ff @(posedge clk_i) begin
    ent_q.geo   <= geo_q[SqrtSteps];
    ent_q.cdist <= root_q[SqrtSteps];
    ent_q.hit   <= (root_q[SqrtSteps] != '0) && (root_q[SqrtSteps] < rsum);
  end

  assign valid_o = vld_q[FrontLat-1];
  assign ent_o   = ent_q;

endmodule

/* sv/ecc_queue.sv */
// short fifo between the front and back parts
`timescale 1ns / 1ps

module ecc_queue import ecc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  fe_t  data_i,
  output logic full_o,
  output logic valid_o,
  output fe_t  data_o
);

  fe_t              mem_q [QDepth];
  logic [QPtrW-1:0] wr_q;
  logic [QPtrW-1:0] rd_q;
  logic [QPtrW:0]   cnt_q;
  logic [QPtrW:0]   cnt_d;
  logic             push;
  logic             pop;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign push    = push_i && !full_o;
  assign pop     = (cnt_q != '0);
  assign valid_o = pop;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + (QPtrW+1)'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - (QPtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (pop) begin
        rd_q <= rd_q + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* sv/ecc_back.sv */
// back end: normal and weight division, velocity exchange, push apart
`timescale 1ns / 1ps

module ecc_back import ecc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  fe_t       ent_i,
  output logic      valid_o,
  output item_out_t res_o
);

  localparam int unsigned BackLat = DivQuoW + 10;

  typedef struct packed {
    item_in_t           item;
    logic               hit;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic [31:0]        ka;
    logic [31:0]        kb;
    logic [3:0][31:0]   npos;
  } ctx_t;

  logic [BackLat-1:0] vld_q;
  fe_t                e0_q;
  fe_t                e1_q;
  fe_t                dly_q [DivQuoW];
  logic [DivNumW-1:0] num_nx_q, num_ny_q, num_ka_q, num_kb_q;
  logic [DivDenW-1:0] den_n_q, den_k_q;
  logic [DivQuoW-1:0] q_nx, q_ny, q_ka, q_kb;
  logic [32:0]        mx, my, msum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[BackLat-2:0], valid_i};
    end
  end

  // numerators with the rounding half of the divisor folded in
  assign mx   = e0_q.geo.dx[32] ? 33'(-e0_q.geo.dx) : 33'(e0_q.geo.dx);
  assign my   = e0_q.geo.dy[32] ? 33'(-e0_q.geo.dy) : 33'(e0_q.geo.dy);
  assign msum = 33'(e0_q.geo.item.a_mass) + 33'(e0_q.geo.item.b_mass);

  always_ff @(posedge clk_i) begin
    e0_q     <= ent_i;
    e1_q     <= e0_q;
    num_nx_q <= (DivNumW'(mx) << 30) + DivNumW'(e0_q.cdist >> 1);
    num_ny_q <= (DivNumW'(my) << 30) + DivNumW'(e0_q.cdist >> 1);
    num_ka_q <= (DivNumW'(e0_q.geo.item.b_mass) << 31) + DivNumW'(msum >> 1);
    num_kb_q <= (DivNumW'(e0_q.geo.item.a_mass) << 31) + DivNumW'(msum >> 1);
    den_n_q  <= DivDenW'(e0_q.cdist);
    den_k_q  <= DivDenW'(msum);
  end

  ecc_div #(.NumW(DivNumW), .DenW(DivDenW), .QuoW(DivQuoW)) u_div_nx (
    .clk_i, .num_i(num_nx_q), .den_i(den_n_q), .quo_o(q_nx));
  ecc_div #(.NumW(DivNumW), .DenW(DivDenW), .QuoW(DivQuoW)) u_div_ny (
    .clk_i, .num_i(num_ny_q), .den_i(den_n_q), .quo_o(q_ny));
  ecc_div #(.NumW(DivNumW), .DenW(DivDenW), .QuoW(DivQuoW)) u_div_ka (
    .clk_i, .num_i(num_ka_q), .den_i(den_k_q), .quo_o(q_ka));
  ecc_div #(.NumW(DivNumW), .DenW(DivDenW), .QuoW(DivQuoW)) u_div_kb (
    .clk_i, .num_i(num_kb_q), .den_i(den_k_q), .quo_o(q_kb));

  always_ff @(posedge clk_i) begin
    dly_q[0] <= e1_q;
    for (int i = 1; i < DivQuoW; i++) begin
      dly_q[i] <= dly_q[i-1];
    end
  end

  // math stages
  ctx_t               c1_q, c2_q, c3_q, c4_q, c5_q, c6_q, c7_q;
  logic [33:0]        ov1_q;
  prod_t              ppx2_q, ppy2_q, pax2_q, pay2_q, pbx2_q, pby2_q;
  logic               npx2_q, npy2_q, nax2_q, nay2_q, nbx2_q, nby2_q;
  wide_t              px3_q, py3_q, an3_q, bn3_q;
  wide_t              d4_q;
  prod_t              pda5_q, pdb5_q;
  logic               nd5_q;
  wide_t              da6_q, db6_q;
  prod_t              pax7_q, pay7_q, pbx7_q, pby7_q;
  logic               nax7_q, nay7_q, nbx7_q, nby7_q;
  item_out_t          res_q;
  fe_t                de;
  logic [32:0]        msum_d;
  logic [31:0]        anx, any;
  logic [39:0]        dmag, damag, dbmag;

  assign de     = dly_q[DivQuoW-1];
  assign msum_d = 33'(de.geo.item.a_mass) + 33'(de.geo.item.b_mass);

  // stage 1: signed normal, weights, overlap
  always_ff @(posedge clk_i) begin
    c1_q.item <= de.geo.item;
    c1_q.hit  <= de.hit;
    c1_q.nx   <= de.geo.dx[32] ? -$signed(q_nx) : $signed(q_nx);
    c1_q.ny   <= de.geo.dy[32] ? -$signed(q_ny) : $signed(q_ny);
    c1_q.ka   <= (msum_d == '0) ? HalfQ31 : q_ka;
    c1_q.kb   <= (msum_d == '0) ? HalfQ31 : q_kb;
    c1_q.npos <= '0;
    ov1_q     <= 34'(de.geo.item.a_radius) + 34'(de.geo.item.b_radius) - 34'(de.cdist);
  end

  // stage 2: push and projection products
  assign anx = c1_q.nx[31] ? 32'(-c1_q.nx) : 32'(c1_q.nx);
  assign any = c1_q.ny[31] ? 32'(-c1_q.ny) : 32'(c1_q.ny);

  always_ff @(posedge clk_i) begin
    c2_q   <= c1_q;
    ppx2_q <= prod_t'(ov1_q) * prod_t'(anx);
    ppy2_q <= prod_t'(ov1_q) * prod_t'(any);
    pax2_q <= prod_t'(anx) * prod_t'(mag40(sx40(c1_q.item.a_vel_x)));
    pay2_q <= prod_t'(any) * prod_t'(mag40(sx40(c1_q.item.a_vel_y)));
    pbx2_q <= prod_t'(anx) * prod_t'(mag40(sx40(c1_q.item.b_vel_x)));
    pby2_q <= prod_t'(any) * prod_t'(mag40(sx40(c1_q.item.b_vel_y)));
    npx2_q <= c1_q.nx[31];
    npy2_q <= c1_q.ny[31];
    nax2_q <= c1_q.nx[31] ^ c1_q.item.a_vel_x[31];
    nay2_q <= c1_q.ny[31] ^ c1_q.item.a_vel_y[31];
    nbx2_q <= c1_q.nx[31] ^ c1_q.item.b_vel_x[31];
    nby2_q <= c1_q.ny[31] ^ c1_q.item.b_vel_y[31];
  end

  // stage 3: round push and normal projections
  always_ff @(posedge clk_i) begin
    c3_q  <= c2_q;
    px3_q <= rnd_shift(ppx2_q, npx2_q, 31);
    py3_q <= rnd_shift(ppy2_q, npy2_q, 31);
    an3_q <= rnd_shift(pax2_q, nax2_q, 30) + rnd_shift(pay2_q, nay2_q, 30);
    bn3_q <= rnd_shift(pbx2_q, nbx2_q, 30) + rnd_shift(pby2_q, nby2_q, 30);
  end

  // stage 4: relative normal speed, pushed positions
  always_ff @(posedge clk_i) begin
    c4_q.item    <= c3_q.item;
    c4_q.hit     <= c3_q.hit;
    c4_q.nx      <= c3_q.nx;
    c4_q.ny      <= c3_q.ny;
    c4_q.ka      <= c3_q.ka;
    c4_q.kb      <= c3_q.kb;
    c4_q.npos[0] <= sat32(sx40(c3_q.item.a_pos_x) - px3_q);
    c4_q.npos[1] <= sat32(sx40(c3_q.item.a_pos_y) - py3_q);
    c4_q.npos[2] <= sat32(sx40(c3_q.item.b_pos_x) + px3_q);
    c4_q.npos[3] <= sat32(sx40(c3_q.item.b_pos_y) + py3_q);
    d4_q         <= bn3_q - an3_q;
  end

  // stage 5: mass weighting products
  assign dmag = mag40(d4_q);

  always_ff @(posedge clk_i) begin
    c5_q   <= c4_q;
    pda5_q <= prod_t'(dmag[35:0]) * prod_t'(c4_q.ka);
    pdb5_q <= prod_t'(dmag[35:0]) * prod_t'(c4_q.kb);
    nd5_q  <= d4_q[39];
  end

  // stage 6: speed changes along the normal
  always_ff @(posedge clk_i) begin
    c6_q  <= c5_q;
    da6_q <= rnd_shift(pda5_q, nd5_q, 30);
    db6_q <= rnd_shift(pdb5_q, !nd5_q, 30);
  end

  // stage 7: back to x and y
  assign damag = mag40(da6_q);
  assign dbmag = mag40(db6_q);

  always_ff @(posedge clk_i) begin
    c7_q   <= c6_q;
    pax7_q <= prod_t'(damag[35:0]) * prod_t'(mag40(sx40(c6_q.nx)));
    pay7_q <= prod_t'(damag[35:0]) * prod_t'(mag40(sx40(c6_q.ny)));
    pbx7_q <= prod_t'(dbmag[35:0]) * prod_t'(mag40(sx40(c6_q.nx)));
    pby7_q <= prod_t'(dbmag[35:0]) * prod_t'(mag40(sx40(c6_q.ny)));
    nax7_q <= da6_q[39] ^ c6_q.nx[31];
    nay7_q <= da6_q[39] ^ c6_q.ny[31];
    nbx7_q <= db6_q[39] ^ c6_q.nx[31];
    nby7_q <= db6_q[39] ^ c6_q.ny[31];
  end

  // stage 8: result register, pass through when no overlap
  always_ff @(posedge clk_i) begin
    res_q.collided <= c7_q.hit;
    if (c7_q.hit) begin
      res_q.new_a_pos_x <= $signed(c7_q.npos[0]);
      res_q.new_a_pos_y <= $signed(c7_q.npos[1]);
      res_q.new_b_pos_x <= $signed(c7_q.npos[2]);
      res_q.new_b_pos_y <= $signed(c7_q.npos[3]);
      res_q.new_a_vel_x <= sat32(sx40(c7_q.item.a_vel_x) + rnd_shift(pax7_q, nax7_q, 30));
      res_q.new_a_vel_y <= sat32(sx40(c7_q.item.a_vel_y) + rnd_shift(pay7_q, nay7_q, 30));
      res_q.new_b_vel_x <= sat32(sx40(c7_q.item.b_vel_x) + rnd_shift(pbx7_q, nbx7_q, 30));
      res_q.new_b_vel_y <= sat32(sx40(c7_q.item.b_vel_y) + rnd_shift(pby7_q, nby7_q, 30));
    end else begin
      res_q.new_a_pos_x <= c7_q.item.a_pos_x;
      res_q.new_a_pos_y <= c7_q.item.a_pos_y;
      res_q.new_b_pos_x <= c7_q.item.b_pos_x;
      res_q.new_b_pos_y <= c7_q.item.b_pos_y;
      res_q.new_a_vel_x <= c7_q.item.a_vel_x;
      res_q.new_a_vel_y <= c7_q.item.a_vel_y;
      res_q.new_b_vel_x <= c7_q.item.b_vel_x;
      res_q.new_b_vel_y <= c7_q.item.b_vel_y;
    end
  end

  assign valid_o = vld_q[BackLat-1];
  assign res_o   = res_q;

endmodule

/* sv/elastic_circle_collision.sv */
// top level of the two-circle elastic collision resolver
`timescale 1ns / 1ps

// usage
// - drive item_i with one circle pair and raise start; the item is taken at
//   a rising edge where start is high and busy is low
// - each item gives exactly one result on result_o, marked by done_o for a
//   single cycle; the receiver cannot hold it off, so sample it then
// - done_o rises once the accepted item has passed every registered stage
//   (front: offsets, squares and a 34-stage sqrt, one root bit per stage;
//   queue: registered storage; back: four 32-stage dividers for the
//   normal and the mass weights, then eight multiply and round stages)
// - throughput: one item per cycle while busy is low, every stage is pipelined
// - the front classifies overlap, the back resolves it; a two-entry queue
//   sits between them and busy reflects a full queue, which the always
//   draining back end keeps from happening in practice
// - overlapping pairs are pushed apart and their normal speeds exchanged,
//   other pairs (and coincident centres) come out unchanged with collided low
// - reset clears all valid flags; items in flight are dropped
module elastic_circle_collision import ecc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  item_in_t  item_i,
  output logic      done_o,
  output item_out_t result_o
);

  logic fe_valid;
  fe_t  fe_ent;
  logic q_valid;
  fe_t  q_ent;
  logic q_full;

  // item accept
  assign busy = q_full;

  ecc_front u_front (
    .clk_i,
    .rst_ni,
    .valid_i (start && !busy),
    .item_i,
    .valid_o (fe_valid),
    .ent_o   (fe_ent)
  );

  // decouples classification from resolution
  ecc_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (fe_valid),
    .data_i  (fe_ent),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_ent)
  );

  // back end takes one queued item per cycle
  ecc_back u_back (
    .clk_i,
    .rst_ni,
    .valid_i (q_valid),
    .ent_i   (q_ent),
    .valid_o (done_o),
    .res_o   (result_o)
  );

endmodule

/* dv/ecc_checker.sv */
// checker: predicts each circle-pair collision result and compares it with the block output
`timescale 1ns / 1ps

module ecc_checker import ecc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      busy,
  input  item_in_t  item_i,
  input  logic      done_o,
  input  item_out_t result_o,
  output int        fail_cnt_o,
  output int        pending_o
);

  item_out_t expected_q[$];

  function automatic logic [63:0] mag64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // round half away from zero of a*b / 2^s
  function automatic longint rnd_mul(longint a, longint b, int s);
    logic [127:0] p;
    p = mag64(a) * mag64(b);
    p = (p + (128'(1) << (s - 1))) >> s;
    return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic item_out_t resolve_pair(item_in_t c);
    item_out_t r;
    longint ax, ay, bx, by, avx, avy, bvx, bvy, dx, dy, nx, ny, ov, px, py;
    longint an, bn, d, da, db;
    logic [67:0] sq, cand;
    logic [63:0] root, rsum, msum, ka, kb;
    logic [95:0] num;
    ax = c.a_pos_x; ay = c.a_pos_y; bx = c.b_pos_x; by = c.b_pos_y;
    avx = c.a_vel_x; avy = c.a_vel_y; bvx = c.b_vel_x; bvy = c.b_vel_y;
    dx = bx - ax; dy = by - ay;
    sq = 68'(mag64(dx)) * 68'(mag64(dy)) * 0 + 68'(mag64(dx)) * mag64(dx)
         + 68'(mag64(dy)) * mag64(dy);
    root = 0;
    for (int k = 33; k >= 0; k--) begin
      cand = 68'(root | (64'd1 << k));
      if (cand * cand <= sq) root = root | (64'd1 << k);
    end
    rsum = 64'(c.a_radius) + c.b_radius;
    r = '{c.a_pos_x, c.a_pos_y, c.a_vel_x, c.a_vel_y,
          c.b_pos_x, c.b_pos_y, c.b_vel_x, c.b_vel_y, 1'b0};
    if (root != 0 && root < rsum) begin
      num = (96'(mag64(dx)) << 30) + root / 2; nx = longint'(num / root);
      num = (96'(mag64(dy)) << 30) + root / 2; ny = longint'(num / root);
      if (dx < 0) nx = -nx;
      if (dy < 0) ny = -ny;
      ov = longint'(rsum - root);
      px = rnd_mul(ov, nx, 31); py = rnd_mul(ov, ny, 31);
      an = rnd_mul(nx, avx, 30) + rnd_mul(ny, avy, 30);
      bn = rnd_mul(nx, bvx, 30) + rnd_mul(ny, bvy, 30);
      d = bn - an;
      msum = 64'(c.a_mass) + c.b_mass;
      if (msum == 0) begin
        ka = 64'd1 << 30; kb = 64'd1 << 30;
      end else begin
        ka = ((64'(c.b_mass) << 31) + msum / 2) / msum;
        kb = ((64'(c.a_mass) << 31) + msum / 2) / msum;
      end
      da = rnd_mul(d, longint'(ka), 30);
      db = -rnd_mul(d, longint'(kb), 30);
      r.new_a_pos_x = clamp32(ax - px); r.new_a_pos_y = clamp32(ay - py);
      r.new_a_vel_x = clamp32(avx + rnd_mul(da, nx, 30));
      r.new_a_vel_y = clamp32(avy + rnd_mul(da, ny, 30));
      r.new_b_pos_x = clamp32(bx + px); r.new_b_pos_y = clamp32(by + py);
      r.new_b_vel_x = clamp32(bvx + rnd_mul(db, nx, 30));
      r.new_b_vel_y = clamp32(bvy + rnd_mul(db, ny, 30));
      r.collided = 1'b1;
    end
    return r;
  endfunction

  task automatic cmp_field(string nm, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %h, got %h", nm, exp_v, got_v);
      fail_cnt_o++;
    end
  endtask

  assign pending_o = expected_q.size();

  always @(posedge clk_i) begin
    item_out_t e;
    if (rst_ni && start && !busy) expected_q = {expected_q, resolve_pair(item_i)};
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected");
        fail_cnt_o++;
      end else begin
        e = expected_q.pop_front();
        cmp_field("new_a_pos_x", e.new_a_pos_x, result_o.new_a_pos_x);
        cmp_field("new_a_pos_y", e.new_a_pos_y, result_o.new_a_pos_y);
        cmp_field("new_a_vel_x", e.new_a_vel_x, result_o.new_a_vel_x);
        cmp_field("new_a_vel_y", e.new_a_vel_y, result_o.new_a_vel_y);
        cmp_field("new_b_pos_x", e.new_b_pos_x, result_o.new_b_pos_x);
        cmp_field("new_b_pos_y", e.new_b_pos_y, result_o.new_b_pos_y);
        cmp_field("new_b_vel_x", e.new_b_vel_x, result_o.new_b_vel_x);
        cmp_field("new_b_vel_y", e.new_b_vel_y, result_o.new_b_vel_y);
        cmp_field("collided", 32'(e.collided), 32'(result_o.collided));
      end
    end
  end

endmodule

/* dv/elastic_circle_collision_tb.sv */
// testbench top: drives circle pairs into the collision block and gives the verdict
`timescale 1ns / 1ps

module elastic_circle_collision_tb;
  import ecc_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  item_in_t  item_i = '0;
  logic      done_o;
  item_out_t result_o;
  int        fail_cnt;
  int        pending;

  // tail wait, longer than the block latency
  localparam int DrainCycles = 120;

  elastic_circle_collision i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .done_o(done_o), .result_o(result_o)
  );

  ecc_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .done_o(done_o), .result_o(result_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // random signed value, sometimes near the extremes, sometimes small
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7FFF_0000 + $urandom_range(0, 32'hFFFF);
      2: return 32'h8000_0000 + $urandom_range(0, 32'hFFFF);
      default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
    endcase
  endfunction

  function automatic item_in_t rand_pair();
    item_in_t c;
    logic [31:0] sep;
    c.a_pos_x = rand_coord(); c.a_pos_y = rand_coord();
    c.a_vel_x = rand_coord(); c.a_vel_y = rand_coord();
    c.b_vel_x = rand_coord(); c.b_vel_y = rand_coord();
    c.a_mass = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 32'h00FF_FFFF);
    c.b_mass = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 32'h00FF_FFFF);
    if ($urandom_range(0, 3) != 0) begin
      // mostly overlapping pairs: nearby centres, radii sized to cover the gap
      sep = $urandom_range(0, 32'h0040_0000);
      c.b_pos_x = c.a_pos_x + 32'($signed(sep) - 32'sh0020_0000);
      c.b_pos_y = c.a_pos_y + 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      c.a_radius = $urandom_range(0, 32'h0030_0000);
      c.b_radius = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 32'h0030_0000);
    end else begin
      c.b_pos_x = rand_coord(); c.b_pos_y = rand_coord();
      c.a_radius = $urandom(); c.b_radius = $urandom();
    end
    return c;
  endfunction

  task automatic send_pair(item_in_t c, int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    int guard;
    start <= 1'b0;
    guard = 0;
    @(posedge clk_i);
    while (pending != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  initial begin
    item_in_t c;
    int idle_pct;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: no overlap, touching, coincident centres, zero masses, extremes
    c = '0;
    c.a_mass = 32'h1_0000; c.b_mass = 32'h1_0000;
    c.b_pos_x = 32'h10_0000; c.a_radius = 32'h1_0000; c.b_radius = 32'h1_0000;
    send_pair(c, 0);
    c.a_radius = 32'h8_0000; c.b_radius = 32'h8_0000;   // exactly touching
    send_pair(c, 0);
    c.b_radius = 32'h8_0001; c.a_vel_x = 32'h2_0000; c.b_vel_x = 32'hFFFE_0000;
    send_pair(c, 0);
    c.b_pos_x = 32'h0;                                   // coincident centres
    send_pair(c, 0);
    c.b_pos_x = 32'h3_0000; c.b_pos_y = 32'hFFFC_0000;
    c.a_mass = 0; c.b_mass = 0;                         // both massless
    send_pair(c, 0);
    c.a_mass = 32'h5_0000;                              // one massless
    send_pair(c, 0);
    c.a_mass = 32'hFFFF_FFFF; c.b_mass = 32'hFFFF_FFFF;
    send_pair(c, 0);
    c = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
          32'h1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'hFFFF_FFFF, 32'hFFFF_FFFF};
    send_pair(c, 0);                                     // farthest apart, saturation
    c.b_pos_x = 32'h7FFF_0000; c.b_pos_y = 32'h7FFF_FFFF;
    send_pair(c, 0);
    c = '{32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h1, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1};
    send_pair(c, 0);
    c = '1;
    send_pair(c, 0);
    c = '0;
    send_pair(c, 0);
    // pause until every expected result is back
    wait_idle();

    // random phases: no idling, heavy sender idling, receiver stall (none possible),
    // light sender idling
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 58 : (ph == 3) ? 8 : 0;
      for (int i = 0; i < 150; i++) send_pair(rand_pair(), idle_pct);
      if (ph == 1) wait_idle();
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* elastic_circle_collision.f */
sv/ecc_pkg.sv
sv/ecc_div.sv
sv/ecc_front.sv
sv/ecc_queue.sv
sv/ecc_back.sv
sv/elastic_circle_collision.sv
dv/ecc_checker.sv
dv/elastic_circle_collision_tb.sv
